// ===== rtl/usic_pkg.sv =====
package usic_pkg;

  // Set geometry; the entry count is a power of two
  localparam int SET_ENTRIES = 1024;
  localparam int SLOT_BITS   = $clog2(SET_ENTRIES);
  localparam int COUNT_BITS  = $clog2(SET_ENTRIES + 1);

  // Bucket epoch kept with every stored id; epoch zero marks a cleared slot
  localparam int EPOCH_BITS = 8;
  localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
  localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = '1;

  // Multiplicative hash: slot = low bits of (h ^ (h >> HASH_SHIFT))
  localparam logic [63:0] HASH_MULT  = 64'h9E37_79B9_7F4A_7C15;
  localparam int          HASH_SHIFT = 29;
  localparam int          HASH_BITS  = HASH_SHIFT + SLOT_BITS;
  localparam int          LO_BITS    = (HASH_BITS + 1) / 2;
  localparam int          HI_BITS    = HASH_BITS - LO_BITS;
  localparam logic [HASH_BITS-1:0] HASH_K = HASH_MULT[HASH_BITS-1:0];
  localparam logic [LO_BITS-1:0]   K_LO   = HASH_K[LO_BITS-1:0];
  localparam logic [HI_BITS-1:0]   K_HI   = HASH_K[HASH_BITS-1:LO_BITS];

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Configuration port
  localparam int  ADDR_BITS        = 3;
  localparam logic REG_ELEMENT_SIZE = 1'b0;
  localparam logic REG_SIGNED       = 1'b1;

  // Element size codes
  localparam logic [1:0] SIZE_1B = 2'd0;
  localparam logic [1:0] SIZE_2B = 2'd1;
  localparam logic [1:0] SIZE_4B = 2'd2;
  localparam logic [1:0] SIZE_8B = 2'd3;

  typedef struct packed {
    logic [1:0] element_size_code;
    logic       signed_elements;
  } cfg_t;

  typedef struct packed {
    logic [63:0] element_raw;
    logic        last_element;
  } element_t;

  typedef struct packed {
    logic signed [63:0] segment_id;
    logic               id_valid;
    logic               bucket_done;
    logic               overflow_seen;
  } result_t;

  // Classified element handed from front to back
  typedef struct packed {
    logic [63:0]          id;
    logic [SLOT_BITS-1:0] home;
    logic                 last;
    logic                 zero;
  } job_t;

  typedef struct packed {
    logic [EPOCH_BITS-1:0] epoch;
    logic [63:0]           id;
  } slot_word_t;

  localparam int WORD_BITS = $bits(slot_word_t);

endpackage

// ===== rtl/usic_ram.sv =====
module usic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one port, read the other with a registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/usic_front.sv =====
module usic_front (
  input  logic              clk,
  input  logic              rst,
  input  usic_pkg::cfg_t    cfg,
  input  logic              push,
  output logic              full,
  input  usic_pkg::element_t element,
  input  logic              hold,
  input  logic              q_full,
  output logic              q_push,
  output usic_pkg::job_t    q_data
);
  import usic_pkg::*;

  logic                    accept;
  logic [63:0]             id_ext;
  logic [HI_BITS-1:0]      a_hi;
  logic [LO_BITS-1:0]      a_lo;

  logic                    s1_valid;
  logic [63:0]             s1_id;
  logic                    s1_last;
  logic                    s1_zero;
  logic [2*LO_BITS-1:0]    pp_ll;
  logic [HI_BITS-1:0]      pp_hl;
  logic [HI_BITS-1:0]      pp_lh;

  logic [HI_BITS-1:0]      mid_sum;
  logic [HASH_BITS-1:0]    hash;

  function automatic logic [63:0] extend(input logic [63:0] raw, input cfg_t c);
    case (c.element_size_code)
      SIZE_1B: extend = {{56{c.signed_elements & raw[7]}}, raw[7:0]};
      SIZE_2B: extend = {{48{c.signed_elements & raw[15]}}, raw[15:0]};
      SIZE_4B: extend = {{32{c.signed_elements & raw[31]}}, raw[31:0]};
      default: extend = raw;
    endcase
  endfunction

  // Take a request while the stage can drain into the queue and hold is low
  assign q_push = s1_valid && !q_full;
  assign full   = hold || (s1_valid && q_full);
  assign accept = push && !full;

  assign id_ext = extend(element.element_raw, cfg);
  assign a_lo   = id_ext[LO_BITS-1:0];
  assign a_hi   = id_ext[HASH_BITS-1:LO_BITS];

  // Stage one: extended id and the hash partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (q_push) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_id   <= id_ext;
      s1_last <= element.last_element;
      s1_zero <= (id_ext == 64'd0);
      pp_ll   <= (2*LO_BITS)'(a_lo) * (2*LO_BITS)'(K_LO);
      pp_hl   <= a_hi * K_LO[HI_BITS-1:0];
      pp_lh   <= a_lo[HI_BITS-1:0] * K_HI;
    end
  end

  // Stage two: combine products, fold the high bits into the slot
  assign mid_sum = pp_hl + pp_lh;
  assign hash    = pp_ll[HASH_BITS-1:0] + {mid_sum, {LO_BITS{1'b0}}};

  always_comb begin
    q_data.id   = s1_id;
    q_data.home = hash[SLOT_BITS-1:0] ^ hash[HASH_BITS-1:HASH_SHIFT];
    q_data.last = s1_last;
    q_data.zero = s1_zero;
  end

endmodule

// ===== rtl/usic_queue.sv =====
module usic_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  usic_pkg::job_t wdata,
  output logic           full,
  input  logic           pop,
  output usic_pkg::job_t head,
  output logic           empty
);
  import usic_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  job_t                entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == CNT_BITS'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== rtl/usic_back.sv =====
module usic_back (
  input  logic              clk,
  input  logic              rst,
  input  usic_pkg::job_t    q_head,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              clearing,
  output logic              empty,
  input  logic              pop,
  output usic_pkg::result_t result
);
  import usic_pkg::*;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_CHECK, S_WAIT} state_t;

  state_t                state, state_next;
  logic [EPOCH_BITS-1:0] epoch, epoch_next;
  logic [COUNT_BITS-1:0] count, count_next;
  logic                  ovf, ovf_next;
  job_t                  cur, cur_next;
  logic [SLOT_BITS-1:0]  slot, slot_next;
  logic [COUNT_BITS-1:0] probes, probes_next;
  logic [SLOT_BITS-1:0]  clr_addr, clr_addr_next;
  logic                  out_valid, out_valid_next;
  result_t               out_res, out_res_next;
  result_t               pend, pend_next;
  logic                  sweep_after, sweep_after_next;

  logic                  ram_we;
  logic [SLOT_BITS-1:0]  ram_waddr;
  slot_word_t            ram_wdata;
  logic [SLOT_BITS-1:0]  ram_raddr;
  logic [WORD_BITS-1:0]  ram_rdata;
  slot_word_t            rd_word;

  logic                  occupied;
  logic                  match;
  logic                  slot_free;
  logic                  finish;
  logic                  fresh;
  logic                  ovf_hit;
  logic                  fin_last;
  logic                  ovf_after;
  logic                  need_res;
  logic                  sweep;
  result_t               res;

  usic_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (SET_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_word   = ram_rdata;
  assign occupied  = (rd_word.epoch == epoch);
  assign match     = occupied && (rd_word.id == cur.id);
  assign slot_free = !out_valid || pop;
  assign clearing  = (state == S_CLEAR);
  assign empty     = !out_valid;
  assign result    = out_res;

  always_comb begin
    state_next       = state;
    epoch_next       = epoch;
    count_next       = count;
    ovf_next         = ovf;
    cur_next         = cur;
    slot_next        = slot;
    probes_next      = probes;
    clr_addr_next    = clr_addr;
    out_valid_next   = out_valid && !pop;
    out_res_next     = out_res;
    pend_next        = pend;
    sweep_after_next = sweep_after;
    q_pop            = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = slot;
    ram_wdata.epoch  = epoch;
    ram_wdata.id     = cur.id;
    ram_raddr        = slot;
    finish           = 1'b0;
    fresh            = 1'b0;
    ovf_hit          = 1'b0;
    fin_last         = cur.last;

    case (state)
      // Sweep the store back to epoch zero
      S_CLEAR: begin
        ram_we          = 1'b1;
        ram_waddr       = clr_addr;
        ram_wdata.epoch = '0;
        ram_wdata.id    = '0;
        clr_addr_next   = clr_addr + 1'b1;
        if (clr_addr == SLOT_BITS'(SET_ENTRIES - 1)) begin
          epoch_next = EPOCH_FIRST;
          state_next = S_IDLE;
        end
      end
      // Take the next request; zero ids skip the lookup
      S_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          cur_next = q_head;
          if (q_head.zero) begin
            finish   = 1'b1;
            fin_last = q_head.last;
          end else begin
            ram_raddr   = q_head.home;
            slot_next   = q_head.home;
            probes_next = '0;
            state_next  = S_CHECK;
          end
        end
      end
      // Inspect the probed slot: hit, insert, advance or report overflow
      S_CHECK: begin
        if (occupied && !match) begin
          if (probes == COUNT_BITS'(SET_ENTRIES - 1)) begin
            finish  = 1'b1;
            ovf_hit = 1'b1;
          end else begin
            slot_next   = slot + 1'b1;
            ram_raddr   = slot + 1'b1;
            probes_next = probes + 1'b1;
          end
        end else if (!occupied) begin
          finish = 1'b1;
          if (count >= COUNT_BITS'(SET_ENTRIES)) begin
            ovf_hit = 1'b1;
          end else begin
            ram_we     = 1'b1;
            count_next = count + 1'b1;
            fresh      = 1'b1;
          end
        end else begin
          finish = 1'b1;
        end
      end
      // Hold the result until the output register frees up
      S_WAIT: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_res_next   = pend;
          clr_addr_next  = '0;
          state_next     = sweep_after ? S_CLEAR : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Close out the element: report, then drop the bucket on the last one
    ovf_after         = ovf | ovf_hit;
    need_res          = fresh | fin_last;
    sweep             = fin_last && (epoch == EPOCH_LAST);
    res.segment_id    = fresh ? $signed(cur.id) : 64'sd0;
    res.id_valid      = fresh;
    res.bucket_done   = fin_last;
    res.overflow_seen = ovf_after;
    if (finish) begin
      ovf_next = ovf_after;
      if (fin_last) begin
        count_next = '0;
        ovf_next   = 1'b0;
        epoch_next = epoch + 1'b1;
      end
      if (need_res && !slot_free) begin
        pend_next        = res;
        sweep_after_next = sweep;
        state_next       = S_WAIT;
      end else begin
        if (need_res) begin
          out_valid_next = 1'b1;
          out_res_next   = res;
        end
        clr_addr_next = '0;
        state_next    = sweep ? S_CLEAR : S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      epoch       <= EPOCH_FIRST;
      count       <= '0;
      ovf         <= 1'b0;
      clr_addr    <= '0;
      probes      <= '0;
      out_valid   <= 1'b0;
      sweep_after <= 1'b0;
    end else begin
      state       <= state_next;
      epoch       <= epoch_next;
      count       <= count_next;
      ovf         <= ovf_next;
      clr_addr    <= clr_addr_next;
      probes      <= probes_next;
      out_valid   <= out_valid_next;
      sweep_after <= sweep_after_next;
    end
    cur     <= cur_next;
    slot    <= slot_next;
    out_res <= out_res_next;
    pend    <= pend_next;
  end

endmodule

// ===== rtl/unique_segment_id_collector.sv =====
// Channel   Handshake              Payload
// -------   ---------------------  ---------------------------------------------
// element   push / full            element_raw, last_element
// result    pop / empty            segment_id, id_valid, bucket_done, overflow_seen
// config    psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
// Flow: the front takes a request per cycle while full is low and registers the
// id and the hash partial products; the combined hash goes to the queue. The back
// reads the slot from the id store's registered read port, then compares or
// inserts, moving on one slot per further probe, up to SET_ENTRIES slots; a zero
// id skips the lookup. Reset: a pass clears the id store with full held high; the
// same pass runs after every 255th bucket when the epoch tag wraps.
// Stalls: a four-entry queue parts front and back; the back holds a finished
// result while the result register is taken.
module unique_segment_id_collector (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  usic_pkg::element_t               element,
  output logic                             empty,
  input  logic                             pop,
  output usic_pkg::result_t                result,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [usic_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import usic_pkg::*;

  cfg_t  cfg;
  logic  cfg_write;
  logic  clearing;
  logic  q_full;
  logic  q_push;
  job_t  q_data;
  logic  q_pop;
  job_t  q_head;
  logic  q_empty;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.element_size_code <= SIZE_1B;
      cfg.signed_elements   <= 1'b0;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_ELEMENT_SIZE: cfg.element_size_code <= pwdata[1:0];
        REG_SIGNED:       cfg.signed_elements   <= pwdata[0];
        default:          cfg                   <= cfg;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ELEMENT_SIZE: prdata = {30'd0, cfg.element_size_code};
      REG_SIGNED:       prdata = {31'd0, cfg.signed_elements};
      default:          prdata = 32'd0;
    endcase
  end

  usic_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .push    (push),
    .full    (full),
    .element (element),
    .hold    (clearing),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_data)
  );

  usic_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_data),
    .full  (q_full),
    .pop   (q_pop),
    .head  (q_head),
    .empty (q_empty)
  );

  usic_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_head   (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .clearing (clearing),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule
